[rtl/core/dpca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpca_pkg: shared types and codes for the dual port console arbiter
// Holds function codes, channel and mode codes and the arbiter state record.
// ----------------------------------------------------------------------------
package dpca_pkg;

    localparam int TimeW = 32;

    // Function codes of an input item
    localparam logic [2:0] FUNC_PROCESS = 3'd0;
    localparam logic [2:0] FUNC_LOCK    = 3'd1;
    localparam logic [2:0] FUNC_UNLOCK  = 3'd2;
    localparam logic [2:0] FUNC_SWITCH  = 3'd3;
    localparam logic [2:0] FUNC_TOUCH   = 3'd4;

    // Channel codes
    localparam logic [1:0] CH_NONE = 2'd0;
    localparam logic [1:0] CH_A    = 2'd1;
    localparam logic [1:0] CH_B    = 2'd2;
    localparam logic [1:0] CH_BAD  = 2'd3;

    // Mode codes as reported on the result channel
    localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_CODE_LOCKED = 2'd2;

    // Register reset values
    localparam logic [TimeW-1:0] IDLE_TIMEOUT_RST = 32'd1000;
    localparam logic [TimeW-1:0] LOCK_TIMEOUT_RST = 32'd5000;

    // Arbiter mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_ACTIVE = 3'b010,
        MODE_LOCKED = 3'b100
    } mode_t;

    // Arbiter state record
    typedef struct packed {
        mode_t            mode;
        logic [1:0]       channel;
        logic [TimeW-1:0] activity_time;
        logic [TimeW-1:0] lock_time;
    } arb_state_t;

    // Timeout settings passed from the register file
    typedef struct packed {
        logic [TimeW-1:0] idle_timeout;
        logic [TimeW-1:0] lock_timeout;
    } arb_cfg_t;

endpackage
`default_nettype wire

[rtl/core/dpca_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpca_regs: configuration register file
// APB-style write and read of the idle and lock timeout registers.
// ----------------------------------------------------------------------------
module dpca_regs (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output dpca_pkg::arb_cfg_t    cfg
);

    logic [31:0] idle_timeout_reg;
    logic [31:0] lock_timeout_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Write the selected timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= dpca_pkg::IDLE_TIMEOUT_RST;
            lock_timeout_reg <= dpca_pkg::LOCK_TIMEOUT_RST;
        end else if (wr_en) begin
            if (paddr[2]) begin
                lock_timeout_reg <= pwdata;
            end else begin
                idle_timeout_reg <= pwdata;
            end
        end
    end

    // Return the selected register
    assign prdata = paddr[2] ? lock_timeout_reg : idle_timeout_reg;

    assign cfg.idle_timeout = idle_timeout_reg;
    assign cfg.lock_timeout = lock_timeout_reg;

endmodule
`default_nettype wire

[rtl/core/dpca_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpca_step: arbiter next-state logic
// Computes the next arbiter state and the accept flag for one item.
// ----------------------------------------------------------------------------
module dpca_step (
    input  wire dpca_pkg::arb_state_t cur,
    input  wire dpca_pkg::arb_cfg_t   cfg,
    input  wire logic [2:0]        func,
    input  wire logic [1:0]        channel,
    input  wire logic              a_has_data,
    input  wire logic              b_has_data,
    input  wire logic [31:0]       now_ms,
    output dpca_pkg::arb_state_t   nxt,
    output logic                   accepted
);

    logic [31:0]      lock_elapsed;
    logic [31:0]      act_elapsed;
    logic             lock_late;
    logic             idle_late;
    logic [1:0]       ch;
    dpca_pkg::mode_t  mode_p;
    logic             own;
    logic             other;

    // Wrap-safe elapsed times
    assign lock_elapsed = now_ms - cur.lock_time;
    assign act_elapsed  = now_ms - cur.activity_time;
    assign lock_late    = lock_elapsed >= cfg.lock_timeout;
    assign idle_late    = act_elapsed >= cfg.idle_timeout;

    // Treat the unused channel code as none
    assign ch = (channel == dpca_pkg::CH_BAD) ? dpca_pkg::CH_NONE : channel;

    assign own   = (cur.channel == dpca_pkg::CH_A) ? a_has_data : b_has_data;
    assign other = (cur.channel == dpca_pkg::CH_A) ? b_has_data : a_has_data;

    // Decode the operation
    always_comb begin
        nxt      = cur;
        accepted = 1'b1;
        mode_p   = cur.mode;
        unique case (func)
            dpca_pkg::FUNC_PROCESS: begin
                // Release an expired lock first
                if (cur.mode == dpca_pkg::MODE_LOCKED && lock_late) begin
                    mode_p = dpca_pkg::MODE_ACTIVE;
                end
                nxt.mode = mode_p;
                unique case (mode_p)
                    dpca_pkg::MODE_IDLE: begin
                        if (a_has_data || b_has_data) begin
                            nxt.channel       = a_has_data ? dpca_pkg::CH_A : dpca_pkg::CH_B;
                            nxt.mode          = dpca_pkg::MODE_ACTIVE;
                            nxt.activity_time = now_ms;
                        end
                    end
                    dpca_pkg::MODE_ACTIVE: begin
                        if (cur.channel == dpca_pkg::CH_A || cur.channel == dpca_pkg::CH_B) begin
                            priority if (own) begin
                                nxt.activity_time = now_ms;
                            end else if (other && idle_late) begin
                                nxt.channel = (cur.channel == dpca_pkg::CH_A) ?
                                              dpca_pkg::CH_B : dpca_pkg::CH_A;
                                nxt.activity_time = now_ms;
                            end else if (idle_late) begin
                                nxt.mode = dpca_pkg::MODE_IDLE;
                            end
                        end
                    end
                    default: begin
                        // Locked: owner data refreshes the lock stamp
                        if ((cur.channel == dpca_pkg::CH_A && a_has_data) ||
                            (cur.channel == dpca_pkg::CH_B && b_has_data)) begin
                            nxt.lock_time = now_ms;
                        end
                    end
                endcase
            end
            dpca_pkg::FUNC_LOCK: begin
                if (cur.mode == dpca_pkg::MODE_LOCKED && cur.channel != ch) begin
                    accepted = 1'b0;
                end else begin
                    nxt.mode      = dpca_pkg::MODE_LOCKED;
                    nxt.channel   = ch;
                    nxt.lock_time = now_ms;
                end
            end
            dpca_pkg::FUNC_UNLOCK: begin
                if (cur.mode == dpca_pkg::MODE_LOCKED) begin
                    nxt.mode          = dpca_pkg::MODE_ACTIVE;
                    nxt.activity_time = now_ms;
                end
            end
            dpca_pkg::FUNC_SWITCH: begin
                if (cur.mode == dpca_pkg::MODE_LOCKED) begin
                    accepted = 1'b0;
                end else begin
                    if (ch != dpca_pkg::CH_NONE) begin
                        nxt.channel = ch;
                    end
                    nxt.mode          = dpca_pkg::MODE_ACTIVE;
                    nxt.activity_time = now_ms;
                end
            end
            dpca_pkg::FUNC_TOUCH: begin
                if (cur.channel == ch) begin
                    nxt.activity_time = now_ms;
                    if (cur.mode == dpca_pkg::MODE_LOCKED) begin
                        nxt.lock_time = now_ms;
                    end
                end
            end
            default: begin
                // Unused function codes leave the state alone
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/dual_port_console_arbiter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_port_console_arbiter: console ownership arbiter for two channels
// Decides which of channels A and B owns the console, with idle, active and
// locked modes and millisecond timeouts.
//
// Usage:
//   Input items (operation, channel, data flags, time) arrive on the s_
//   valid/ready channel; one result (owner, mode, accept flag, any data)
//   leaves on the m_ valid/ready channel for every accepted item.
//   An accepted item waits in the input register and moves into the result
//   register when the result slot is free or its result is being taken.
//   Throughput: one item per cycle while m_ready is high; the arbiter state
//   updates as an item moves from the input register into the result register.
//   Stall: when m_ready is low the result is held; the input register still
//   takes one more item, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous): both registers empty, mode idle, owner
//   channel A, time stamps zero, timeouts 1000 and 5000 ms.
//   Timeouts are written through the APB port at addresses 0 and 4. The user
//   must do so only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_port_console_arbiter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [1:0]  s_channel,
    input  wire logic        s_a_has_data,
    input  wire logic        s_b_has_data,
    input  wire logic [31:0] s_now_ms,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_active_channel,
    output logic      [1:0]  m_mode_now,
    output logic             m_accepted,
    output logic             m_any_data
);

    dpca_pkg::arb_cfg_t   cfg;
    dpca_pkg::arb_state_t state_reg;
    dpca_pkg::arb_state_t state_next;
    logic                 step_acc;

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [1:0]  in_channel_reg;
    logic        in_a_reg;
    logic        in_b_reg;
    logic [31:0] in_now_reg;

    logic        out_valid_reg;
    logic [1:0]  out_channel_reg;
    logic [1:0]  out_mode_reg;
    logic        out_acc_reg;
    logic        out_any_reg;
    logic [1:0]  mode_code;
    logic        adv;

    dpca_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpca_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .func       (in_func_reg),
        .channel    (in_channel_reg),
        .a_has_data (in_a_reg),
        .b_has_data (in_b_reg),
        .now_ms     (in_now_reg),
        .nxt        (state_next),
        .accepted   (step_acc)
    );

    // Advance when the input register holds an item and the result slot frees
    assign adv     = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg    <= s_func;
            in_channel_reg <= s_channel;
            in_a_reg       <= s_a_has_data;
            in_b_reg       <= s_b_has_data;
            in_now_reg     <= s_now_ms;
        end
    end

    // Arbiter state advances with each transfer into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= dpca_pkg::MODE_IDLE;
            state_reg.channel       <= dpca_pkg::CH_A;
            state_reg.activity_time <= '0;
            state_reg.lock_time     <= '0;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    // Map the one-hot mode to its reported code
    always_comb begin
        unique case (state_next.mode)
            dpca_pkg::MODE_IDLE:   mode_code = dpca_pkg::MODE_CODE_IDLE;
            dpca_pkg::MODE_ACTIVE: mode_code = dpca_pkg::MODE_CODE_ACTIVE;
            dpca_pkg::MODE_LOCKED: mode_code = dpca_pkg::MODE_CODE_LOCKED;
            default:               mode_code = dpca_pkg::MODE_CODE_IDLE;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_channel_reg <= state_next.channel;
            out_mode_reg    <= mode_code;
            out_acc_reg     <= step_acc;
            out_any_reg     <= in_a_reg | in_b_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_active_channel = out_channel_reg;
    assign m_mode_now       = out_mode_reg;
    assign m_accepted       = out_acc_reg;
    assign m_any_data       = out_any_reg;

`ifndef SYNTHESIS
    // A refused lock or switch leaves the arbiter state untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !step_acc) |=> $stable(state_reg))
        else $error("refused request changed arbiter state");

    // The any-data flag follows the item that produced the result
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (m_any_data == ($past(in_a_reg) | $past(in_b_reg))))
        else $error("any_data does not match its item");

    // State only moves together with a transfer into the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(state_reg))
        else $error("arbiter state changed without a transfer");

    // An empty input register always takes a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");
`endif

endmodule
`default_nettype wire
